/* rtl/sepq_pkg.sv */
`default_nettype none

package sepq_pkg;

    localparam int NUM_LEVELS  = 4;
    localparam int QUEUE_DEPTH = 256;

    localparam int LVL_W  = $clog2(NUM_LEVELS);
    localparam int PTR_W  = $clog2(QUEUE_DEPTH);
    localparam int FILL_W = $clog2(QUEUE_DEPTH + 1);
    localparam int ADDR_W = $clog2(NUM_LEVELS * QUEUE_DEPTH);
    localparam int OCC_W  = $clog2(NUM_LEVELS * QUEUE_DEPTH + 1);

    // Drop-rate rule: the rate is only checked once more than this many events were pushed.
    localparam logic [31:0] PUSH_LIMIT = 32'd1000;

    localparam logic [1:0] CMD_PUSH  = 2'd0;
    localparam logic [1:0] CMD_POP   = 2'd1;
    localparam logic [1:0] CMD_READ  = 2'd2;
    localparam logic [1:0] CMD_CLEAR = 2'd3;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_BAD_PRIO = 2'd1;
    localparam logic [1:0] ST_FULL     = 2'd2;
    localparam logic [1:0] ST_EMPTY    = 2'd3;

    localparam logic [2:0] SEL_PUSHED  = 3'd0;
    localparam logic [2:0] SEL_POPPED  = 3'd1;
    localparam logic [2:0] SEL_DROPPED = 3'd2;
    localparam logic [2:0] SEL_LEVEL0  = 3'd3;

    typedef struct packed {
        logic [1:0]  command;
        logic [2:0]  priority_req;
        logic [31:0] payload;
        logic [2:0]  counter_select;
    } request_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] data_out;
        logic [31:0] seq_out;
        logic [1:0]  prio_out;
        logic [31:0] counter_value;
        logic [10:0] occupancy;
        logic        healthy;
    } result_t;

    typedef struct packed {
        logic load;
        logic exec;
        logic emit;
    } ctrl_cmd_t;

endpackage

`default_nettype wire

/* rtl/sepq_ctrl.sv */
`default_nettype none

module sepq_ctrl
    import sepq_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      start,
    output logic           busy,
    output ctrl_cmd_t      cmd
);

    typedef enum logic {
        IDLE,
        EXEC
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   done_reg;
    logic   done_next;

    always_comb
    begin
        state_next = state_reg;
        done_next  = 1'b0;
        unique case (state_reg)
            IDLE:
            begin
                if (start)
                begin
                    state_next = EXEC;
                end
            end
            EXEC:
            begin
                state_next = IDLE;
                done_next  = 1'b1;
            end
            default:
            begin
                state_next = IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    assign busy     = (state_reg == EXEC);
    assign cmd.load = start && (state_reg == IDLE);
    assign cmd.exec = (state_reg == EXEC);
    assign cmd.emit = done_reg;

endmodule

`default_nettype wire

/* rtl/sepq_datapath.sv */
`default_nettype none

module sepq_datapath
    import sepq_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire ctrl_cmd_t cmd,
    input  wire request_t  request,
    output result_t        result
);

    request_t req_reg;

    logic [63:0] mem [NUM_LEVELS * QUEUE_DEPTH];
    logic [63:0] mem_q_reg;

    logic [PTR_W-1:0]  head_reg [NUM_LEVELS];
    logic [PTR_W-1:0]  tail_reg [NUM_LEVELS];
    logic [FILL_W-1:0] fill_reg [NUM_LEVELS];
    logic [31:0]       drop_reg [NUM_LEVELS];
    logic [31:0]       seq_reg;
    logic [31:0]       pushed_reg;
    logic [31:0]       popped_reg;
    logic [31:0]       drop_total_reg;
    logic [OCC_W-1:0]  occ_reg;

    logic [1:0]       status_reg;
    logic [1:0]       status_next;
    logic [31:0]      cval_reg;
    logic [31:0]      cval_next;
    logic [LVL_W-1:0] plvl_reg;
    logic             pop_ok_reg;

    logic              prio_ok;
    logic [LVL_W-1:0]  prio_lvl;
    logic [LVL_W-1:0]  pop_lvl;
    logic              any_full;
    logic              any_held;
    logic [LVL_W-1:0]  op_lvl;
    logic [PTR_W-1:0]  ptr_sel;
    logic [PTR_W-1:0]  ptr_inc;
    logic              full_sel;
    logic [ADDR_W-1:0] mem_addr;
    logic [2:0]        sel_off;
    logic              sel_ok;
    logic [LVL_W-1:0]  sel_lvl;
    logic              do_push;
    logic              do_drop;
    logic              do_pop;
    logic              do_clear;
    logic [38:0]       drop_x100;
    logic              rate_bad;

    assign prio_ok  = ({1'b0, req_reg.priority_req} < 4'(NUM_LEVELS));
    assign prio_lvl = LVL_W'(req_reg.priority_req);

    // Highest non-empty level wins; the ascending scan leaves the last hit.
    always_comb
    begin
        pop_lvl  = '0;
        any_held = 1'b0;
        any_full = 1'b0;
        for (int i = 0; i < NUM_LEVELS; i++)
        begin
            if (fill_reg[i] != '0)
            begin
                pop_lvl  = LVL_W'(i);
                any_held = 1'b1;
            end
            if (fill_reg[i] == FILL_W'(QUEUE_DEPTH))
            begin
                any_full = 1'b1;
            end
        end
    end

    assign op_lvl   = (req_reg.command == CMD_PUSH) ? prio_lvl : pop_lvl;
    assign ptr_sel  = (req_reg.command == CMD_PUSH) ? tail_reg[op_lvl] : head_reg[op_lvl];
    assign ptr_inc  = (ptr_sel == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : ptr_sel + 1'b1;
    assign full_sel = (fill_reg[op_lvl] == FILL_W'(QUEUE_DEPTH));
    assign mem_addr = ADDR_W'(op_lvl) * ADDR_W'(QUEUE_DEPTH) + ADDR_W'(ptr_sel);

    assign sel_off = req_reg.counter_select - SEL_LEVEL0;
    assign sel_ok  = (req_reg.counter_select >= SEL_LEVEL0)
                     && ({1'b0, sel_off} < 4'(NUM_LEVELS));
    assign sel_lvl = LVL_W'(sel_off);

    assign do_push  = cmd.exec && (req_reg.command == CMD_PUSH) && prio_ok && !full_sel;
    assign do_drop  = cmd.exec && (req_reg.command == CMD_PUSH) && prio_ok && full_sel;
    assign do_pop   = cmd.exec && (req_reg.command == CMD_POP) && any_held;
    assign do_clear = cmd.exec && (req_reg.command == CMD_CLEAR);

    always_comb
    begin
        status_next = ST_OK;
        cval_next   = '0;
        unique case (req_reg.command)
            CMD_PUSH:
            begin
                if (!prio_ok)
                begin
                    status_next = ST_BAD_PRIO;
                end
                else if (full_sel)
                begin
                    status_next = ST_FULL;
                end
            end
            CMD_POP:
            begin
                if (!any_held)
                begin
                    status_next = ST_EMPTY;
                end
            end
            CMD_READ:
            begin
                unique case (req_reg.counter_select)
                    SEL_PUSHED:  cval_next = pushed_reg;
                    SEL_POPPED:  cval_next = popped_reg;
                    SEL_DROPPED: cval_next = drop_total_reg;
                    default:     cval_next = sel_ok ? drop_reg[sel_lvl] : '0;
                endcase
            end
            default:
            begin
                status_next = ST_OK;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            req_reg <= request;
        end
        if (do_push)
        begin
            mem[mem_addr] <= {seq_reg, req_reg.payload};
        end
        if (do_pop)
        begin
            mem_q_reg <= mem[mem_addr];
        end
        if (cmd.exec)
        begin
            status_reg <= status_next;
            cval_reg   <= cval_next;
            plvl_reg   <= pop_lvl;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_LEVELS; i++)
            begin
                head_reg[i] <= '0;
                tail_reg[i] <= '0;
                fill_reg[i] <= '0;
                drop_reg[i] <= '0;
            end
            seq_reg        <= '0;
            pushed_reg     <= '0;
            popped_reg     <= '0;
            drop_total_reg <= '0;
            occ_reg        <= '0;
            pop_ok_reg     <= 1'b0;
        end
        else
        begin
            if (cmd.exec)
            begin
                pop_ok_reg <= do_pop;
            end
            if (do_push || do_drop)
            begin
                seq_reg <= seq_reg + 32'd1;
            end
            if (do_push)
            begin
                tail_reg[op_lvl] <= ptr_inc;
                fill_reg[op_lvl] <= fill_reg[op_lvl] + 1'b1;
                pushed_reg       <= pushed_reg + 32'd1;
                occ_reg          <= occ_reg + 1'b1;
            end
            if (do_drop)
            begin
                drop_reg[op_lvl] <= drop_reg[op_lvl] + 32'd1;
                drop_total_reg   <= drop_total_reg + 32'd1;
            end
            if (do_pop)
            begin
                head_reg[op_lvl] <= ptr_inc;
                fill_reg[op_lvl] <= fill_reg[op_lvl] - 1'b1;
                popped_reg       <= popped_reg + 32'd1;
                occ_reg          <= occ_reg - 1'b1;
            end
            if (do_clear)
            begin
                for (int i = 0; i < NUM_LEVELS; i++)
                begin
                    drop_reg[i] <= '0;
                end
                pushed_reg     <= '0;
                popped_reg     <= '0;
                drop_total_reg <= '0;
            end
        end
    end

    // Times 100 as 64 + 32 + 4, so the compare needs no multiplier.
    assign drop_x100 = {1'b0, drop_total_reg, 6'b0} + {2'b0, drop_total_reg, 5'b0}
                       + {5'b0, drop_total_reg, 2'b0};
    assign rate_bad  = (pushed_reg > PUSH_LIMIT) && (drop_x100 > {7'b0, pushed_reg});

    // State changes only at the end of the execute cycle, so these reflect
    // the state after the command while the result is shown.
    assign result.status        = status_reg;
    assign result.data_out      = pop_ok_reg ? mem_q_reg[31:0] : '0;
    assign result.seq_out       = pop_ok_reg ? mem_q_reg[63:32] : '0;
    assign result.prio_out      = pop_ok_reg ? 2'(plvl_reg) : '0;
    assign result.counter_value = cval_reg;
    assign result.occupancy     = 11'(occ_reg);
    assign result.healthy       = !any_full && !rate_bad;

endmodule

`default_nettype wire

/* rtl/strict_priority_event_queue.sv */
`default_nettype none

// Strict-priority event queue: one FIFO per priority level in a shared
// event memory, with statistics counters and a health flag.
//
// Request channel: a command is taken at a rising edge where start is high
// and busy is low. busy is high for the one execute cycle that follows.
// Result channel: done is high for exactly one cycle, the cycle after the
// execute cycle, and result holds the answer during that cycle. There is
// no backpressure; the receiver must take every result when done is high.
//
// Each command has an execute cycle that updates the level's
// pointers and counters and reads or writes the event memory, then the
// result cycle, which shows the registered memory read data. A new command
// may be started in the result cycle, while that result is still shown.
//
// Reset clears pointers, fill counts and all counters; the event memory is
// not cleared, since a pop only reads entries that a push has written.

module strict_priority_event_queue
    import sepq_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     start,
    output logic          busy,
    input  wire request_t request,
    output logic          done,
    output result_t       result
);

    ctrl_cmd_t cmd;

    sepq_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .cmd   (cmd)
    );

    sepq_datapath u_datapath (
        .clk     (clk),
        .rst_n   (rst_n),
        .cmd     (cmd),
        .request (request),
        .result  (result)
    );

    assign done = cmd.emit;

endmodule

`default_nettype wire

/* rtl/sepq_checker.sv */
`default_nettype none

module sepq_assertions
    import sepq_pkg::*;
(
    input wire logic     clk,
    input wire logic     rst_n,
    input wire logic     start,
    input wire logic     busy,
    input wire request_t request,
    input wire logic     done,
    input wire result_t  result
);

    // Every accepted transfer is executed in exactly one busy cycle.
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy)
        else $error("accepted transfer did not raise busy");

    a_busy_done: assert property (@(posedge clk) disable iff (!rst_n)
        busy |=> done && !busy)
        else $error("execute cycle not followed by a result");

    a_done_needs_exec: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(busy))
        else $error("result without a preceding execute cycle");

    // An empty pop can only be reported when nothing is held.
    a_empty_occ: assert property (@(posedge clk) disable iff (!rst_n)
        done && (result.status == ST_EMPTY) |-> (result.occupancy == 11'd0))
        else $error("empty status with nonzero occupancy");

    // A drop means that level is still full, so the block cannot be healthy.
    a_full_unhealthy: assert property (@(posedge clk) disable iff (!rst_n)
        done && (result.status == ST_FULL) |-> !result.healthy)
        else $error("queue full drop reported as healthy");

endmodule

bind strict_priority_event_queue sepq_assertions u_sepq_checker (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (start),
    .busy    (busy),
    .request (request),
    .done    (done),
    .result  (result)
);

`default_nettype wire

/* test/sepq_checker.sv */
`timescale 1ns / 100ps

module sepq_checker
    import sepq_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     start,
    input  logic     busy,
    input  request_t request,
    input  logic     done,
    input  result_t  result,
    output int       fail_count,
    output int       pending
);

    // Mirror of the queue state, kept in step with every accepted command.
    logic [63:0] slot_mem [NUM_LEVELS][QUEUE_DEPTH];
    int          head_idx [NUM_LEVELS];
    int          tail_idx [NUM_LEVELS];
    int          level_fill [NUM_LEVELS];
    logic [31:0] level_drops [NUM_LEVELS];
    logic [31:0] next_seq;
    logic [31:0] pushed_total;
    logic [31:0] popped_total;

    result_t expected_results [$];
    result_t want;
    int      errors;

    function automatic logic [31:0] dropped_sum();
        logic [31:0] sum;
        sum = '0;
        for (int l = 0; l < NUM_LEVELS; l++)
        begin
            sum = sum + level_drops[l];
        end
        return sum;
    endfunction

    function automatic logic queue_healthy();
        for (int l = 0; l < NUM_LEVELS; l++)
        begin
            if (level_fill[l] >= QUEUE_DEPTH)
            begin
                return 1'b0;
            end
        end
        // Drop rate above one percent, in exact integer form.
        if (pushed_total > PUSH_LIMIT
            && 64'(dropped_sum()) * 64'd100 > 64'(pushed_total))
        begin
            return 1'b0;
        end
        return 1'b1;
    endfunction

    function automatic result_t serve_command(request_t r);
        result_t     res;
        logic [63:0] entry;
        int          lvl;
        int          occ;
        res = '0;
        case (r.command)
            CMD_PUSH:
            begin
                if (r.priority_req >= NUM_LEVELS)
                begin
                    res.status = ST_BAD_PRIO;
                end
                else
                begin
                    lvl = int'(r.priority_req);
                    entry = {next_seq, r.payload};
                    next_seq = next_seq + 32'd1;
                    if (level_fill[lvl] >= QUEUE_DEPTH)
                    begin
                        level_drops[lvl] = level_drops[lvl] + 32'd1;
                        res.status = ST_FULL;
                    end
                    else
                    begin
                        slot_mem[lvl][tail_idx[lvl]] = entry;
                        tail_idx[lvl] = (tail_idx[lvl] + 1) % QUEUE_DEPTH;
                        level_fill[lvl]++;
                        pushed_total = pushed_total + 32'd1;
                    end
                end
            end
            CMD_POP:
            begin
                res.status = ST_EMPTY;
                for (lvl = NUM_LEVELS - 1; lvl >= 0; lvl--)
                begin
                    if (level_fill[lvl] != 0)
                    begin
                        entry = slot_mem[lvl][head_idx[lvl]];
                        head_idx[lvl] = (head_idx[lvl] + 1) % QUEUE_DEPTH;
                        level_fill[lvl]--;
                        popped_total = popped_total + 32'd1;
                        res.status = ST_OK;
                        res.data_out = entry[31:0];
                        res.seq_out = entry[63:32];
                        res.prio_out = 2'(lvl);
                        break;
                    end
                end
            end
            CMD_READ:
            begin
                if (r.counter_select == SEL_PUSHED)
                begin
                    res.counter_value = pushed_total;
                end
                else if (r.counter_select == SEL_POPPED)
                begin
                    res.counter_value = popped_total;
                end
                else if (r.counter_select == SEL_DROPPED)
                begin
                    res.counter_value = dropped_sum();
                end
                else if (int'(r.counter_select) - int'(SEL_LEVEL0) < NUM_LEVELS)
                begin
                    res.counter_value =
                        level_drops[int'(r.counter_select) - int'(SEL_LEVEL0)];
                end
            end
            default:
            begin
                // Clearing leaves the sequence number and the queues alone.
                pushed_total = '0;
                popped_total = '0;
                for (lvl = 0; lvl < NUM_LEVELS; lvl++)
                begin
                    level_drops[lvl] = '0;
                end
            end
        endcase
        occ = 0;
        for (lvl = 0; lvl < NUM_LEVELS; lvl++)
        begin
            occ += level_fill[lvl];
        end
        res.occupancy = 11'(occ);
        res.healthy = queue_healthy();
        return res;
    endfunction

    task automatic check_field(input string name, input logic [31:0] exp_v,
                               input logic [31:0] got_v);
        if (got_v !== exp_v)
        begin
            $error("%s: expected 0x%0h, got 0x%0h", name, exp_v, got_v);
            errors++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int l = 0; l < NUM_LEVELS; l++)
            begin
                head_idx[l] = 0;
                tail_idx[l] = 0;
                level_fill[l] = 0;
                level_drops[l] = '0;
            end
            next_seq = '0;
            pushed_total = '0;
            popped_total = '0;
            expected_results.delete();
            errors = 0;
            fail_count <= 0;
            pending <= 0;
        end
        else
        begin
            // A result transfer always belongs to an earlier command, so it
            // is matched before a command taken at the same edge is modeled.
            if (done)
            begin
                if (expected_results.size() == 0)
                begin
                    $error("result transfer with no command outstanding");
                    errors++;
                end
                else
                begin
                    want = expected_results.pop_front();
                    check_field("status", 32'(want.status), 32'(result.status));
                    check_field("data_out", want.data_out, result.data_out);
                    check_field("seq_out", want.seq_out, result.seq_out);
                    check_field("prio_out", 32'(want.prio_out), 32'(result.prio_out));
                    check_field("counter_value", want.counter_value,
                                result.counter_value);
                    check_field("occupancy", 32'(want.occupancy),
                                32'(result.occupancy));
                    check_field("healthy", 32'(want.healthy), 32'(result.healthy));
                end
            end
            if (start && !busy)
            begin
                expected_results.push_back(serve_command(request));
            end
            pending <= expected_results.size();
            fail_count <= errors;
        end
    end

endmodule

/* test/strict_priority_event_queue_test.sv */
`timescale 1ns / 100ps

module strict_priority_event_queue_test;

    import sepq_pkg::*;

    localparam int STALL_LIMIT = 2000;

    logic     clk;
    logic     rst_n;
    logic     start;
    logic     busy;
    request_t request;
    logic     done;
    result_t  result;
    int       fail_count;
    int       pending;
    int       stall_cycles;
    logic     no_idle;

    strict_priority_event_queue i_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .busy    (busy),
        .request (request),
        .done    (done),
        .result  (result)
    );

    sepq_checker i_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .request    (request),
        .done       (done),
        .result     (result),
        .fail_count (fail_count),
        .pending    (pending)
    );

    initial clk = 1'b0;

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // The run is ended if no transfer happens on either channel for too long.
    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || done)
        begin
            stall_cycles <= 0;
        end
        else
        begin
            stall_cycles <= stall_cycles + 1;
        end
        if (stall_cycles >= STALL_LIMIT)
        begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    function automatic request_t make_req(logic [1:0] cmd, logic [2:0] prio,
                                          logic [31:0] data, logic [2:0] sel);
        request_t r;
        r.command = cmd;
        r.priority_req = prio;
        r.payload = data;
        r.counter_select = sel;
        return r;
    endfunction

    function automatic request_t random_request();
        request_t r;
        int       pick;
        r.payload = $urandom;
        r.counter_select = 3'($urandom_range(7, 0));
        if ($urandom_range(99, 0) < 15)
        begin
            r.priority_req = 3'($urandom_range(7, NUM_LEVELS));
        end
        else
        begin
            r.priority_req = 3'($urandom_range(NUM_LEVELS - 1, 0));
        end
        pick = $urandom_range(99, 0);
        if (pick < 45)
        begin
            r.command = CMD_PUSH;
        end
        else if (pick < 80)
        begin
            r.command = CMD_POP;
        end
        else if (pick < 95)
        begin
            r.command = CMD_READ;
        end
        else
        begin
            r.command = CMD_CLEAR;
        end
        return r;
    endfunction

    function automatic int rand_gap();
        int pick;
        pick = $urandom_range(99, 0);
        if (no_idle || pick < 60)
        begin
            return 0;
        end
        else if (pick < 90)
        begin
            return $urandom_range(3, 1);
        end
        else if (pick < 98)
        begin
            return $urandom_range(10, 4);
        end
        return $urandom_range(60, 20);
    endfunction

    // Returns at the edge where the command transfer takes place; start is
    // left high so that a back-to-back command keeps it high.
    task automatic issue(input request_t r, input int gap);
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start <= 1'b1;
        request <= r;
        forever
        begin
            @(posedge clk);
            if (!busy)
            begin
                break;
            end
        end
    endtask

    task automatic wait_drained();
        start <= 1'b0;
        @(posedge clk);
        while (pending != 0)
        begin
            @(posedge clk);
        end
    endtask

    initial
    begin
        rst_n <= 1'b0;
        start <= 1'b0;
        request <= '0;
        no_idle = 1'b0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part: empty pop, invalid levels, payload extremes, every
        // counter, priority order on pop, and a clear.
        issue(make_req(CMD_POP, 3'd5, 32'hFFFF_FFFF, 3'd7), rand_gap());
        issue(make_req(CMD_PUSH, 3'd7, 32'hFFFF_FFFF, 3'd7), rand_gap());
        issue(make_req(CMD_PUSH, 3'(NUM_LEVELS), 32'h0, 3'd0), rand_gap());
        issue(make_req(CMD_PUSH, 3'd0, 32'h0, 3'd0), rand_gap());
        issue(make_req(CMD_PUSH, 3'(NUM_LEVELS - 1), 32'hFFFF_FFFF, 3'd7), rand_gap());
        issue(make_req(CMD_PUSH, 3'd1, 32'hA5A5_A5A5, 3'd2), rand_gap());
        issue(make_req(CMD_PUSH, 3'd2, 32'h5A5A_5A5A, 3'd5), rand_gap());
        issue(make_req(CMD_PUSH, 3'(NUM_LEVELS - 1), 32'h1234_5678, 3'd1), rand_gap());
        for (int s = 0; s < 8; s++)
        begin
            issue(make_req(CMD_READ, 3'($urandom), $urandom, 3'(s)), rand_gap());
        end
        repeat (6) issue(make_req(CMD_POP, 3'($urandom), $urandom, 3'($urandom)),
                         rand_gap());
        issue(make_req(CMD_CLEAR, 3'd7, 32'hFFFF_FFFF, 3'd7), rand_gap());
        issue(make_req(CMD_READ, 3'd0, 32'h0, SEL_PUSHED), rand_gap());
        issue(make_req(CMD_READ, 3'd0, 32'h0, SEL_POPPED), rand_gap());

        // Random mix, alternating stretches with and without idle gaps.
        for (int i = 0; i < 200; i++)
        begin
            no_idle = ((i / 50) % 2) == 1;
            if (i == 100)
            begin
                wait_drained();
            end
            issue(random_request(), rand_gap());
        end
        no_idle = 1'b0;

        // Push the top level past full so that some events are dropped, read
        // every counter, then pop a few so the level is no longer full.
        repeat (QUEUE_DEPTH + 4)
        begin
            issue(make_req(CMD_PUSH, 3'(NUM_LEVELS - 1), $urandom, 3'($urandom)),
                  rand_gap());
        end
        for (int s = 0; s < 8; s++)
        begin
            issue(make_req(CMD_READ, 3'($urandom), $urandom, 3'(s)), rand_gap());
        end
        repeat (4)
        begin
            issue(make_req(CMD_POP, 3'($urandom), $urandom, 3'($urandom)),
                  rand_gap());
        end
        issue(make_req(CMD_CLEAR, 3'($urandom), $urandom, 3'($urandom)), rand_gap());
        issue(make_req(CMD_READ, 3'($urandom), $urandom, SEL_DROPPED), rand_gap());

        wait_drained();
        repeat (4) @(posedge clk);
        if (fail_count == 0)
        begin
            $display("Simulation PASSED");
        end
        else
        begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

/* strict_priority_event_queue.f */
rtl/sepq_pkg.sv
rtl/sepq_ctrl.sv
rtl/sepq_datapath.sv
rtl/strict_priority_event_queue.sv
rtl/sepq_checker.sv
test/sepq_checker.sv
test/strict_priority_event_queue_test.sv
